// File: design/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// Types and codes shared by the deadband force regulator and its channels.
// ----------------------------------------------------------------------------
package dfr_pkg;

   localparam int FORCE_W = 24;
   localparam int ERROR_W = 25;
   localparam int POS_W   = 32;
   localparam int ZONE_W  = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [ZONE_W-1:0] {
      ZONE_INNER_HOLD = 3'd0,
      ZONE_FAST       = 3'd1,
      ZONE_SLOW       = 3'd2,
      ZONE_RETRACT    = 3'd3,
      ZONE_GAP_HOLD   = 3'd4
   } zone_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_FORCE = 3'd0,
      CSR_FILTER_GAIN  = 3'd1,
      CSR_INNER_BAND   = 3'd2,
      CSR_OUTER_BAND   = 3'd3,
      CSR_HIGH_BAND    = 3'd4,
      CSR_FAST_STEP    = 3'd5,
      CSR_SLOW_STEP    = 3'd6,
      CSR_RETRACT_GAIN = 3'd7
   } csr_index_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_FILT = 6'b000010,
      ST_UPD  = 6'b000100,
      ST_ERR  = 6'b001000,
      ST_MUL  = 6'b010000,
      ST_CMD  = 6'b100000
   } state_type;

endpackage

// File: design/dfr_req_if.sv
// ----------------------------------------------------------------------------
// dfr_req_if
// Request channel: tick or seed item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dfr_req_if import dfr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic signed [FORCE_W-1:0] force_sample;
   logic signed [POS_W-1:0]   seed_position;

   modport source (output valid, kind, force_sample, seed_position, input ready);
   modport sink   (input valid, kind, force_sample, seed_position, output ready);
endinterface

// File: design/dfr_rsp_if.sv
// ----------------------------------------------------------------------------
// dfr_rsp_if
// Response channel: one regulator result per control tick.
// ----------------------------------------------------------------------------
interface dfr_rsp_if import dfr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [FORCE_W-1:0] filtered_force;
   logic signed [ERROR_W-1:0] force_err;
   logic signed [POS_W-1:0]   command_position;
   logic [ZONE_W-1:0]         zone;
   logic                      send_command;

   modport source (output valid, filtered_force, force_err, command_position, zone,
                   send_command, input ready);
   modport sink   (input valid, filtered_force, force_err, command_position, zone,
                   send_command, output ready);
endinterface

// File: design/deadband_force_regulator.sv
// ----------------------------------------------------------------------------
// deadband_force_regulator
// Low-pass filters a contact force, sorts the error into five zones and
// produces a saturated position command with a send flag.
//
//   channel   dir  handshake              payload
//   req_chan  in   valid/ready            kind, force_sample, seed_position
//   rsp_chan  out  valid/ready            filtered_force .. send_command
//   csr_*     in   csr_we, no wait        csr_index, csr_wdata
//
// A tick passes through FILT, UPD, ERR, MUL and CMD after acceptance; its
// response is registered on leaving CMD and the next request is taken back
// in IDLE. One shared multiplier serves the filter product and then the
// retract gain product. A seed item is absorbed in IDLE with no response.
// A pending response stalls the final step until the sink takes it; the
// next request is accepted while a finished response waits.
// Reset is synchronous and restores the register defaults and zero state.
// ----------------------------------------------------------------------------
module deadband_force_regulator import dfr_pkg::*; #(
   parameter int SEND_THRESHOLD_NM = 1000
) (
   input  logic                   clock,
   input  logic                   reset,
   dfr_req_if.sink                req_chan,
   dfr_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [32:0] SEND_LIMIT = 33'(SEND_THRESHOLD_NM);

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [37:0] v);
      logic signed [37:0] hi;
      logic signed [37:0] lo;
      hi = 38'sh0_7FFF_FFFF;
      lo = -38'sh0_8000_0000;
      if (v > hi)
         return 32'sh7FFF_FFFF;
      else if (v < lo)
         return 32'sh8000_0000;
      else
         return v[31:0];
   endfunction

   // configuration
   logic signed [23:0] target_ff;
   logic [15:0]        alpha_ff;
   logic [22:0]        inner_ff;
   logic [22:0]        outer_ff;
   logic [22:0]        high_ff;
   logic [19:0]        fast_ff;
   logic [19:0]        slow_ff;
   logic [19:0]        gain_ff;

   // state
   state_type          state_ff, state_in;
   logic signed [39:0] fs_ff, fs_in;
   logic signed [31:0] eq_ff, eq_in;
   logic signed [31:0] sent_ff, sent_in;
   logic signed [23:0] sample_ff, sample_in;
   logic signed [57:0] prod_ff, prod_in;
   logic signed [24:0] err_ff, err_in;

   // response
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [23:0] rsp_ff_ff, rsp_ff_in;
   logic signed [24:0] rsp_err_ff, rsp_err_in;
   logic signed [31:0] rsp_cmd_ff, rsp_cmd_in;
   zone_type           rsp_zone_ff, rsp_zone_in;
   logic               rsp_send_ff, rsp_send_in;

   // datapath
   logic signed [40:0] diff_w;
   logic signed [41:0] mul_a;
   logic signed [20:0] mul_b;
   logic signed [62:0] mul_p;
   logic signed [40:0] fs_sum_w;
   logic signed [24:0] err_w;
   logic [24:0]        abs_err;
   logic               in_inner, in_fast, in_slow, in_retract;
   logic signed [37:0] adv_w;
   logic signed [37:0] retract_w;
   logic signed [31:0] cmd_w;
   zone_type           zone_w;
   logic               advance_w;
   logic signed [32:0] cmd_diff_w;
   logic [32:0]        cmd_dist_w;
   logic               send_w;
   logic               out_free;
   logic               req_fire;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid & req_chan.ready;
   assign out_free       = ~rsp_valid_ff | rsp_chan.ready;

   assign diff_w = $signed({sample_ff[23], sample_ff, 16'b0}) - $signed({fs_ff[39], fs_ff});

   always_comb begin
      if (state_ff == ST_MUL) begin
         mul_a = 42'(err_ff);
         mul_b = $signed({1'b0, gain_ff});
      end else begin
         mul_a = 42'(diff_w);
         mul_b = $signed({5'b0, alpha_ff});
      end
   end

   assign mul_p    = mul_a * mul_b;
   assign fs_sum_w = 41'(fs_ff) + 41'(prod_ff[56:16]);
   assign err_w    = 25'(target_ff) - 25'($signed(fs_ff[39:16]));
   assign abs_err  = err_ff[24] ? 25'(-err_ff) : 25'(err_ff);

   assign in_inner   = abs_err < {2'b0, inner_ff};
   assign in_fast    = ~err_ff[24] & (err_ff[23:0] > {1'b0, outer_ff});
   assign in_slow    = ~err_ff[24] & (err_ff[23:0] > {1'b0, inner_ff});
   assign in_retract = err_ff[24] & (abs_err > {2'b0, high_ff});

   assign adv_w     = 38'(eq_ff) + $signed({18'b0, (in_fast ? fast_ff : slow_ff)});
   assign retract_w = 38'(eq_ff) + 38'($signed(prod_ff[44:8]));

   always_comb begin
      cmd_w     = sent_ff;
      zone_w    = ZONE_GAP_HOLD;
      advance_w = 1'b0;
      priority if (in_inner) begin
         zone_w = ZONE_INNER_HOLD;
      end else if (in_fast) begin
         zone_w    = ZONE_FAST;
         cmd_w     = sat_pos(adv_w);
         advance_w = 1'b1;
      end else if (in_slow) begin
         zone_w    = ZONE_SLOW;
         cmd_w     = sat_pos(adv_w);
         advance_w = 1'b1;
      end else if (in_retract) begin
         zone_w = ZONE_RETRACT;
         cmd_w  = sat_pos(retract_w);
      end else begin
         zone_w = ZONE_GAP_HOLD;
      end
   end

   assign cmd_diff_w = 33'(cmd_w) - 33'(sent_ff);
   assign cmd_dist_w = cmd_diff_w[32] ? 33'(-cmd_diff_w) : 33'(cmd_diff_w);
   assign send_w     = cmd_dist_w > SEND_LIMIT;

   always_comb begin
      state_in     = state_ff;
      fs_in        = fs_ff;
      eq_in        = eq_ff;
      sent_in      = sent_ff;
      sample_in    = sample_ff;
      prod_in      = prod_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_ff_in    = rsp_ff_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_zone_in  = rsp_zone_ff;
      rsp_send_in  = rsp_send_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.kind) begin
                  fs_in   = {req_chan.force_sample, 16'b0};
                  eq_in   = req_chan.seed_position;
                  sent_in = req_chan.seed_position;
               end else begin
                  sample_in = req_chan.force_sample;
                  state_in  = ST_FILT;
               end
            end
         end
         ST_FILT: begin
            prod_in  = mul_p[57:0];
            state_in = ST_UPD;
         end
         ST_UPD: begin
            fs_in    = fs_sum_w[39:0];
            state_in = ST_ERR;
         end
         ST_ERR: begin
            err_in   = err_w;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = mul_p[57:0];
            state_in = ST_CMD;
         end
         ST_CMD: begin
            if (out_free) begin
               if (advance_w)
                  eq_in = cmd_w;
               if (send_w)
                  sent_in = cmd_w;
               rsp_valid_in = 1'b1;
               rsp_ff_in    = fs_ff[39:16];
               rsp_err_in   = err_ff;
               rsp_cmd_in   = cmd_w;
               rsp_zone_in  = zone_w;
               rsp_send_in  = send_w;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fs_ff        <= '0;
         eq_ff        <= '0;
         sent_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= 24'sd25600;
         alpha_ff     <= 16'd328;
         inner_ff     <= 23'd2048;
         outer_ff     <= 23'd5120;
         high_ff      <= 23'd6400;
         fast_ff      <= 20'd2000;
         slow_ff      <= 20'd1000;
         gain_ff      <= 20'd30000;
      end else begin
         state_ff     <= state_in;
         fs_ff        <= fs_in;
         eq_ff        <= eq_in;
         sent_ff      <= sent_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_TARGET_FORCE: target_ff <= csr_wdata;
               CSR_FILTER_GAIN:  alpha_ff  <= csr_wdata[15:0];
               CSR_INNER_BAND:   inner_ff  <= csr_wdata[22:0];
               CSR_OUTER_BAND:   outer_ff  <= csr_wdata[22:0];
               CSR_HIGH_BAND:    high_ff   <= csr_wdata[22:0];
               CSR_FAST_STEP:    fast_ff   <= csr_wdata[19:0];
               CSR_SLOW_STEP:    slow_ff   <= csr_wdata[19:0];
               CSR_RETRACT_GAIN: gain_ff   <= csr_wdata[19:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      prod_ff     <= prod_in;
      err_ff      <= err_in;
      rsp_ff_ff   <= rsp_ff_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_cmd_ff  <= rsp_cmd_in;
      rsp_zone_ff <= rsp_zone_in;
      rsp_send_ff <= rsp_send_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.filtered_force   = rsp_ff_ff;
   assign rsp_chan.force_err        = rsp_err_ff;
   assign rsp_chan.command_position = rsp_cmd_ff;
   assign rsp_chan.zone             = rsp_zone_ff;
   assign rsp_chan.send_command     = rsp_send_ff;

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for deadband_force_regulator. Control ticks and seed
// requests go in over the request channel; a local predictor of the low-pass
// filter, the five-zone decision and the send flag tracks every accepted
// request. Each response is checked field by field against the oldest
// prediction. Directed tests hit the defaults, band edges, saturation, band
// order and register masking. Random phases under many settings follow.
// Both channels stall at random, except during one random phase.
// ----------------------------------------------------------------------------
module testbench;
   import dfr_pkg::*;

   localparam int CLOCK_PERIOD      = 20;
   localparam int RESET_CYCLES      = 10;
   localparam int SETTLE_CYCLES     = 12;
   localparam int DRAIN_LIMIT       = 20000;
   localparam int TIMEOUT_CYCLES    = 400000;
   localparam int SEND_THRESHOLD_NM = 1000;
   localparam int PHASE_ITEMS       = 150;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_SEED = 1'b1;

   localparam logic signed [FORCE_W-1:0] FORCE_MAX = 24'sh7FFFFF;
   localparam logic signed [FORCE_W-1:0] FORCE_MIN = 24'sh800000;

   typedef logic [CSR_DATA_W-1:0] register_set_type [8];

   localparam register_set_type RESET_VALUES =
      '{24'd25600, 24'd328, 24'd2048, 24'd5120, 24'd6400, 24'd2000, 24'd1000, 24'd30000};

   typedef struct {
      logic signed [FORCE_W-1:0] filtered_force;
      logic signed [ERROR_W-1:0] force_err;
      logic signed [POS_W-1:0]   command_position;
      zone_type                  zone;
      logic                      send_command;
   } regulator_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dfr_req_if request_bus ();
   dfr_rsp_if response_bus ();

   deadband_force_regulator #(
      .SEND_THRESHOLD_NM(SEND_THRESHOLD_NM)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (request_bus),
      .rsp_chan  (response_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic signed [FORCE_W-1:0] target_force_q;
   logic [15:0]               filter_gain_q;
   logic [22:0]               inner_band_q;
   logic [22:0]               outer_band_q;
   logic [22:0]               high_band_q;
   logic [19:0]               fast_step_q;
   logic [19:0]               slow_step_q;
   logic [19:0]               retract_gain_q;
   logic signed [39:0]        filter_acc;
   logic signed [POS_W-1:0]   equilibrium_nm;
   logic signed [POS_W-1:0]   sent_nm;

   regulator_result_type due_results [$];
   int                   error_count  = 0;
   bit                   idle_on      = 1'b1;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic logic signed [POS_W-1:0] clamp_position(input longint value);
      if (value > longint'(32'sh7FFFFFFF))
         return 32'sh7FFFFFFF;
      if (value < longint'(32'sh80000000))
         return 32'sh80000000;
      return value[POS_W-1:0];
   endfunction

   function automatic void store_register(input csr_index_type idx,
                                          input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_TARGET_FORCE: target_force_q = value[FORCE_W-1:0];
         CSR_FILTER_GAIN:  filter_gain_q  = value[15:0];
         CSR_INNER_BAND:   inner_band_q   = value[22:0];
         CSR_OUTER_BAND:   outer_band_q   = value[22:0];
         CSR_HIGH_BAND:    high_band_q    = value[22:0];
         CSR_FAST_STEP:    fast_step_q    = value[19:0];
         CSR_SLOW_STEP:    slow_step_q    = value[19:0];
         CSR_RETRACT_GAIN: retract_gain_q = value[19:0];
         default: ;
      endcase
   endfunction

   function automatic regulator_result_type regulate_tick(
         input logic signed [FORCE_W-1:0] raw);
      regulator_result_type r;
      longint delta;
      longint ff;
      longint err;
      longint cmd;
      delta = (longint'(raw) <<< 16) - longint'(filter_acc);
      filter_acc = 40'(longint'(filter_acc) + ((delta * longint'(filter_gain_q)) >>> 16));
      ff  = longint'(filter_acc) >>> 16;
      err = longint'(target_force_q) - ff;
      cmd = longint'(sent_nm);
      if ((err < 0 ? -err : err) < longint'(inner_band_q)) begin
         r.zone = ZONE_INNER_HOLD;
      end else if (err > longint'(outer_band_q)) begin
         equilibrium_nm = clamp_position(longint'(equilibrium_nm) + longint'(fast_step_q));
         cmd = longint'(equilibrium_nm);
         r.zone = ZONE_FAST;
      end else if (err > longint'(inner_band_q)) begin
         equilibrium_nm = clamp_position(longint'(equilibrium_nm) + longint'(slow_step_q));
         cmd = longint'(equilibrium_nm);
         r.zone = ZONE_SLOW;
      end else if (err < -longint'(high_band_q)) begin
         cmd = longint'(clamp_position(longint'(equilibrium_nm) +
                                       ((longint'(retract_gain_q) * err) >>> 8)));
         r.zone = ZONE_RETRACT;
      end else begin
         r.zone = ZONE_GAP_HOLD;
      end
      r.send_command = (cmd - longint'(sent_nm) > SEND_THRESHOLD_NM) ||
                       (longint'(sent_nm) - cmd > SEND_THRESHOLD_NM);
      if (r.send_command)
         sent_nm = cmd[POS_W-1:0];
      r.filtered_force   = ff[FORCE_W-1:0];
      r.force_err        = err[ERROR_W-1:0];
      r.command_position = cmd[POS_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   task automatic send_request(input logic kind, input logic signed [FORCE_W-1:0] force_value,
                               input logic signed [POS_W-1:0] position);
      regulator_result_type due;
      while (idle_on && $urandom_range(99) < 25) begin
         request_bus.valid <= 1'b0;
         @(posedge clock);
      end
      request_bus.valid         <= 1'b1;
      request_bus.kind          <= kind;
      request_bus.force_sample  <= force_value;
      request_bus.seed_position <= position;
      do
         @(posedge clock);
      while (!request_bus.ready);
      if (kind == KIND_SEED) begin
         filter_acc     = {force_value, 16'h0000};
         equilibrium_nm = position;
         sent_nm        = position;
      end else begin
         due = regulate_tick(force_value);
         due_results.insert(due_results.size(), due);
      end
   endtask

   task automatic drain_and_settle();
      request_bus.valid <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && due_results.size() != 0; n++)
         @(posedge clock);
      if (due_results.size() != 0) begin
         error_count++;
         $display("%0t rsp: expected %0d more responses, actual none", $time,
                  due_results.size());
         due_results.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input register_set_type values);
      drain_and_settle();
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= values[i];
         @(posedge clock);
         store_register(csr_index_type'(i), values[i]);
      end
      csr_we <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_request(KIND_TICK, '0, $urandom());
      send_request(KIND_TICK, FORCE_MAX, $urandom());
      send_request(KIND_TICK, FORCE_MIN, $urandom());
      send_request(KIND_TICK, 24'sd25600, $urandom());
   endtask

   task automatic test_band_edges();
      int edge_errors [9] = '{99, 100, 101, 300, 301, -99, -100, -500, -501};
      register_set_type s;
      s = RESET_VALUES;
      s[CSR_TARGET_FORCE] = '0;
      s[CSR_INNER_BAND]   = 24'd100;
      s[CSR_OUTER_BAND]   = 24'd300;
      s[CSR_HIGH_BAND]    = 24'd500;
      load_settings(s);
      // hold the filter at zero so the error equals the target
      send_request(KIND_SEED, '0, 32'sd5000);
      foreach (edge_errors[i]) begin
         s[CSR_TARGET_FORCE] = 24'(edge_errors[i]);
         load_settings(s);
         send_request(KIND_TICK, '0, $urandom());
      end
   endtask

   task automatic test_saturation_and_order();
      register_set_type s;
      s = RESET_VALUES;
      s[CSR_TARGET_FORCE] = 24'h7FFFFF;
      s[CSR_FILTER_GAIN]  = '0;
      s[CSR_FAST_STEP]    = 24'h0FFFFF;
      load_settings(s);
      send_request(KIND_SEED, '0, 32'sh7FFFFD00);
      send_request(KIND_TICK, FORCE_MAX, $urandom());
      send_request(KIND_TICK, FORCE_MIN, $urandom());
      s[CSR_TARGET_FORCE] = 24'h800000;
      s[CSR_INNER_BAND]   = '0;
      s[CSR_OUTER_BAND]   = '0;
      s[CSR_HIGH_BAND]    = '0;
      s[CSR_RETRACT_GAIN] = 24'h0FFFFF;
      load_settings(s);
      send_request(KIND_SEED, '0, 32'sh80000000);
      send_request(KIND_TICK, '0, $urandom());
      send_request(KIND_SEED, '0, '0);
      send_request(KIND_TICK, '0, $urandom());
      // outer below inner: the inner test still wins
      s = RESET_VALUES;
      s[CSR_FILTER_GAIN]  = '0;
      s[CSR_INNER_BAND]   = 24'd500;
      s[CSR_OUTER_BAND]   = 24'd100;
      s[CSR_TARGET_FORCE] = 24'd400;
      load_settings(s);
      send_request(KIND_TICK, '0, $urandom());
      s[CSR_TARGET_FORCE] = 24'd600;
      load_settings(s);
      send_request(KIND_TICK, '0, $urandom());
   endtask

   task automatic test_register_masking();
      register_set_type s;
      foreach (s[i])
         s[i] = '1;
      load_settings(s);
      send_request(KIND_TICK, FORCE_MIN, $urandom());
      send_request(KIND_TICK, FORCE_MAX, $urandom());
   endtask

   task automatic test_random_settings();
      int styles [9] = '{0, 2, 1, 2, 3, 2, 4, 1, 2};
      register_set_type s;
      longint spread;
      longint near;
      int roll;
      int inner;
      logic signed [POS_W-1:0] position;
      for (int ph = 0; ph < 9; ph++) begin
         case (styles[ph])
            0: s = RESET_VALUES;
            1: foreach (s[i]) s[i] = 24'($urandom());
            2: begin
               inner = $urandom_range(4096);
               s[CSR_TARGET_FORCE] = 24'(int'($urandom_range(65536)) - 32768);
               s[CSR_FILTER_GAIN]  = 24'($urandom_range(65535, 2048));
               s[CSR_INNER_BAND]   = 24'(inner);
               s[CSR_OUTER_BAND]   = 24'(inner + int'($urandom_range(8192)));
               s[CSR_HIGH_BAND]    = 24'(inner + int'($urandom_range(8192)));
               s[CSR_FAST_STEP]    = 24'($urandom_range(5000));
               s[CSR_SLOW_STEP]    = 24'($urandom_range(3000));
               s[CSR_RETRACT_GAIN] = 24'($urandom_range(1048575));
            end
            3: s = '{24'h800000, '0, '0, '0, '0, '0, '0, '0};
            default: s = '{24'h7FFFFF, 24'h00FFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                           24'h0FFFFF, 24'h0FFFFF, 24'h0FFFFF};
         endcase
         load_settings(s);
         idle_on = (ph != 5);
         spread = 4 * longint'(high_band_q) + 4 * longint'(outer_band_q) + 256;
         if (spread > longint'(FORCE_MAX))
            spread = longint'(FORCE_MAX);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(99);
            near = longint'(target_force_q) + longint'($urandom_range(32'(2 * spread))) - spread;
            if (near > longint'(FORCE_MAX))
               near = longint'(FORCE_MAX);
            if (near < longint'(FORCE_MIN))
               near = longint'(FORCE_MIN);
            case ($urandom_range(3))
               0, 1: position = $urandom();
               2: position = 32'sh7FFFFFFF - $signed($urandom_range(4000000));
               default: position = 32'sh80000000 + $signed($urandom_range(4000000));
            endcase
            if (roll < 5)
               send_request(KIND_SEED, near[FORCE_W-1:0], position);
            else if (roll < 80)
               send_request(KIND_TICK, near[FORCE_W-1:0], position);
            else if (roll < 92)
               send_request(KIND_TICK, $urandom(), position);
            else
               send_request(KIND_TICK, roll[0] ? FORCE_MAX : FORCE_MIN, position);
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      regulator_result_type due;
      response_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && response_bus.valid && response_bus.ready) begin
            if (due_results.size() == 0) begin
               error_count++;
               $display("%0t rsp: expected none, actual command_position %0d", $time,
                        response_bus.command_position);
            end else begin
               due = due_results.pop_front();
               check_field("filtered_force", due.filtered_force, response_bus.filtered_force);
               check_field("force_err", due.force_err, response_bus.force_err);
               check_field("command_position", due.command_position,
                           response_bus.command_position);
               check_field("zone", {61'd0, due.zone}, {61'd0, response_bus.zone});
               check_field("send_command", {63'd0, due.send_command},
                           {63'd0, response_bus.send_command});
            end
         end
         response_bus.ready <= !(idle_on && $urandom_range(99) < 25);
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      reset                     <= 1'b1;
      csr_we                    <= 1'b0;
      csr_index                 <= CSR_TARGET_FORCE;
      csr_wdata                 <= '0;
      request_bus.valid         <= 1'b0;
      request_bus.kind          <= KIND_TICK;
      request_bus.force_sample  <= '0;
      request_bus.seed_position <= '0;
      for (int i = 0; i < 8; i++)
         store_register(csr_index_type'(i), RESET_VALUES[i]);
      filter_acc     = '0;
      equilibrium_nm = '0;
      sent_nm        = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_band_edges();
      test_saturation_and_order();
      test_register_masking();
      test_random_settings();
      drain_and_settle();
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// File: files.f
design/dfr_pkg.sv
design/dfr_req_if.sv
design/dfr_rsp_if.sv
design/deadband_force_regulator.sv
tb/testbench.sv
